>>> sv/spf_pkg.sv
package spf_pkg;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int MODE_W    = 3;
    localparam int RW_W      = 11;
    localparam int POS_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam int SPF_MAX_WIDTH = 1024;

    // Pixel position saturates here
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Front-to-back queue, power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Filter modes; also used as the resolved predictor select
    localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UP    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_AVG   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PAETH = 3'd4;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 1'b1;

    // One classified word, front to back
    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic [PIX_W-1:0]  left;
        logic [PIX_W-1:0]  up;
        logic [PIX_W-1:0]  ul;
        logic [MODE_W-1:0] sel;
        logic              last;
    } spf_item_t;

    // Paeth pick over left (a), up (b), upper-left (c); ties in that order.
    // |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    function automatic logic [PIX_W-1:0] paeth_pick(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c
    );
        logic signed [PIX_W+2:0] da;
        logic signed [PIX_W+2:0] db;
        logic signed [PIX_W+2:0] dc;
        logic [PIX_W-1:0]        pick;
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = $signed({3'b000, a}) + $signed({3'b000, b})
           - $signed({2'b00, c, 1'b0});
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) begin
            pick = a;
        end else if (db <= dc) begin
            pick = b;
        end else begin
            pick = c;
        end
        return pick;
    endfunction

endpackage

>>> sv/spf_front.sv
module spf_front
    import spf_pkg::*;
#(
    parameter int MAX_WIDTH = SPF_MAX_WIDTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [PIX_W-1:0]  s_pixel,
    input  logic              s_last,
    input  logic [MODE_W-1:0] filter_mode,
    input  logic [RW_W-1:0]   row_width,
    output logic              item_valid,
    input  logic              item_ready,
    output spf_item_t         item
);

    localparam int DEPTH = MAX_WIDTH + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [PIX_W-1:0] line_mem [DEPTH];

    logic [AW-1:0]     head_reg, head_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [PIX_W-1:0]  left_reg, left_next;
    logic              st_valid_reg;
    logic [PIX_W-1:0]  st_pix_reg, st_left_reg, up_rd_reg, ul_rd_reg;
    logic [MODE_W-1:0] st_sel_reg;
    logic              st_last_reg, st_ul_zero_reg;

    logic              accept;
    logic [RW_W-1:0]   w_eff;
    logic [AW:0]       up_sum, ul_sum;
    logic [AW-1:0]     up_addr, ul_addr;
    logic              first_row, ul_zero;
    logic [MODE_W-1:0] sel;

    assign s_tready = !st_valid_reg || item_ready;
    assign accept   = s_tvalid && s_tready;

    // Row width: 0 acts as 1, above the store limit clamps
    always_comb begin
        if (row_width == '0) begin
            w_eff = RW_W'(1);
        end else if (32'(row_width) > MAX_WIDTH) begin
            w_eff = RW_W'(MAX_WIDTH);
        end else begin
            w_eff = row_width;
        end
    end

    // Up lies w back, upper-left w+1 back in the circular store
    always_comb begin
        up_sum  = {1'b0, head_reg} + (AW+1)'(DEPTH) - (AW+1)'(w_eff);
        ul_sum  = up_sum - (AW+1)'(1);
        up_addr = (up_sum >= (AW+1)'(DEPTH)) ? AW'(up_sum - (AW+1)'(DEPTH))
                                             : up_sum[AW-1:0];
        ul_addr = (ul_sum >= (AW+1)'(DEPTH)) ? AW'(ul_sum - (AW+1)'(DEPTH))
                                             : ul_sum[AW-1:0];
    end

    assign first_row = pos_reg < w_eff;
    assign ul_zero   = pos_reg <= w_eff;

    always_comb begin
        case (filter_mode)
            MODE_SUB:   sel = (pos_reg == '0) ? MODE_NONE : MODE_SUB;
            MODE_UP:    sel = first_row ? MODE_NONE : MODE_UP;
            MODE_AVG:   sel = first_row ? MODE_NONE : MODE_AVG;
            MODE_PAETH: sel = first_row ? MODE_NONE : MODE_PAETH;
            default:    sel = MODE_NONE;
        endcase
    end

    always_comb begin
        head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        if (s_last) begin
            pos_next  = '0;
            left_next = '0;
        end else begin
            pos_next  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
            left_next = s_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            pos_reg      <= '0;
            left_reg     <= '0;
            st_valid_reg <= 1'b0;
        end else if (accept) begin
            head_reg     <= head_next;
            pos_reg      <= pos_next;
            left_reg     <= left_next;
            st_valid_reg <= 1'b1;
        end else if (item_ready) begin
            st_valid_reg <= 1'b0;
        end
    end

    // Read before write: with w at the store limit the upper-left slot
    // is the one being overwritten, and the old byte is wanted.
    always_ff @(posedge aclk) begin
        if (accept) begin
            line_mem[head_reg] <= s_pixel;
            up_rd_reg          <= line_mem[up_addr];
            ul_rd_reg          <= line_mem[ul_addr];
            st_pix_reg         <= s_pixel;
            st_left_reg        <= left_reg;
            st_sel_reg         <= sel;
            st_last_reg        <= s_last;
            st_ul_zero_reg     <= ul_zero;
        end
    end

    assign item_valid = st_valid_reg;
    always_comb begin
        item.pix  = st_pix_reg;
        item.left = st_left_reg;
        item.up   = up_rd_reg;
        item.ul   = st_ul_zero_reg ? '0 : ul_rd_reg;
        item.sel  = st_sel_reg;
        item.last = st_last_reg;
    end

endmodule

>>> sv/spf_queue.sv
module spf_queue
    import spf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  spf_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output spf_item_t pop_item
);

    spf_item_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]       count_reg, count_next;
    logic                    push, pop;

    assign push_ready = count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/spf_back.sv
module spf_back
    import spf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    output logic             item_ready,
    input  spf_item_t        item,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_residual,
    output logic             m_last
);

    logic             m_valid_reg;
    logic [PIX_W-1:0] res_reg, res_next;
    logic             last_reg;
    logic [PIX_W-1:0] pred;
    logic [PIX_W:0]   avg_sum;

    assign item_ready = !m_valid_reg || m_tready;
    assign avg_sum    = {1'b0, item.left} + {1'b0, item.up};

    always_comb begin
        case (item.sel)
            MODE_SUB:   pred = item.left;
            MODE_UP:    pred = item.up;
            MODE_AVG:   pred = avg_sum[PIX_W:1];
            MODE_PAETH: pred = paeth_pick(item.left, item.up, item.ul);
            default:    pred = '0;
        endcase
        res_next = item.pix - pred;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (item_ready) begin
            m_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid && item_ready) begin
            res_reg  <= res_next;
            last_reg <= item.last;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_residual = res_reg;
    assign m_last     = last_reg;

endmodule

>>> sv/scanline_predictor_filter_core.sv
// Scanline predictor filter: one 8-bit pixel in, one residual byte out.
// s_ channel: pixel words in raster order, s_tlast on the last pixel of an
//   image. m_ channel: residual = pixel - prediction (mod 256), m_tlast copies
//   the input flag. cfg_ channel: index 0 filter mode (0 none, 1 sub, 2 up,
//   3 average, 4 Paeth, others act as none), index 1 row width in pixels.
//   Write config only while no word is in flight; cfg_ready is always high.
// Throughput: one word per clock while m_tready is high, set by the line store,
//   which takes one write and two reads (up, upper-left) per accepted word.
// Path: an accepted word passes the store read/classify stage, then the queue,
//   then the output register, before it shows on m_tvalid.
// Stall: a 4-word queue parts the front from the output register, so the
//   front keeps taking words while m_tready is low until the queue fills;
//   then s_tready drops. The output register holds its word until taken.
// Reset: control state clears, mode 0, row width 1, image position 0.
//   The line store is not cleared: a store slot is only read once the
//   current image has written it, so no clearing pass is needed.
module scanline_predictor_filter_core
    import spf_pkg::*;
#(
    parameter int MAX_WIDTH = SPF_MAX_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input pixels
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] pixel_value
    input  logic                 s_tlast,   // last_of_image
    // residuals
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] residual
    output logic                 m_tlast,   // last_out
    // config writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RW_W-1:0]      cfg_data
);

    logic [MODE_W-1:0] mode_reg;
    logic [RW_W-1:0]   row_width_reg;

    logic      fr_valid, fr_ready;
    spf_item_t fr_item;
    logic      q_valid, q_ready;
    spf_item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_NONE;
            row_width_reg <= RW_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FILTER_MODE: mode_reg      <= cfg_data[MODE_W-1:0];
                REG_ROW_WIDTH:   row_width_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Front: line store access, neighbor fetch and mode resolution
    spf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_pixel     (s_tdata[PIX_W-1:0]),
        .s_last      (s_tlast),
        .filter_mode (mode_reg),
        .row_width   (row_width_reg),
        .item_valid  (fr_valid),
        .item_ready  (fr_ready),
        .item        (fr_item)
    );

    spf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // Back: prediction, subtract, output register
    spf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_residual (m_tdata),
        .m_last     (m_tlast)
    );

    // A full queue with a word waiting in the front must stall the input
    a_front_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (fr_valid && !fr_ready) |-> !s_tready)
        else $error("input taken while front stage is blocked");

    // A word leaving the queue lands in the output register
    a_queue_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> m_tvalid)
        else $error("queued word lost before output register");

    // Output register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
